// ----- hdl/i2a_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, codes and helpers for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

	// format commands
	localparam logic [2:0] CMD_SDEC = 3'd0;
	localparam logic [2:0] CMD_UDEC = 3'd1;
	localparam logic [2:0] CMD_HEXL = 3'd2;
	localparam logic [2:0] CMD_HEXU = 3'd3;
	localparam logic [2:0] CMD_PTR  = 3'd4;

	localparam int NUM_CELLS  = 16;
	localparam int NIB_W      = 4;
	localparam int CONV_STEPS = 32;

	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_LA    = 8'h61;

	// operation applied to every digit cell in the same cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_DABBLE,
		CELL_SHIFT
	} cell_op_t;

	function automatic logic [7:0] hex_char(input logic [NIB_W-1:0] nib, input logic upper);
		logic [7:0] ch;
		if (nib < 4'd10) begin
			ch = CH_ZERO + {4'd0, nib};
		end else begin
			ch = (upper ? CH_UA : CH_LA) + {4'd0, nib} - 8'd10;
		end
		return ch;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/integer_to_ascii_formatter_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats one number per input beat as ASCII text, one character per output
// beat, most significant character first.
// ----------------------------------------------------------------------------
// One item is worked at a time. A row of sixteen nibble cells holds the digits.
// Decimal commands shift all 32 input bits through the cell row with double
// dabble, one bit per cycle; hex and pointer commands load the row directly.
// The leading zero nibbles, 16 minus the digit count, are then shifted out
// one per cycle, and each character leaves as the output side takes a beat.
// The next item is accepted while the last character still waits on the
// output. Commands 5 to 7 are accepted and give no characters.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  command,
	input  wire logic [63:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       character,
	output logic             is_last,
	output logic [4:0]       char_count
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_TRIM,
		ST_PFX0,
		ST_PFX1,
		ST_DIGITS
	} state_t;

	state_t state_q;

	logic [31:0] bin_q;
	logic [4:0]  cnt_q;
	logic [4:0]  ndig_q;
	logic [4:0]  total_q;
	logic        neg_q;
	logic        ptr_q;
	logic        upper_q;
	logic [7:0]  char_q;
	logic        last_q;
	logic [4:0]  count_q;
	logic        out_valid_q;

	logic        in_fire;
	logic        emit_ok;
	logic        is_dec;
	logic        is_hex;
	logic        is_ptr;
	logic        neg_in;
	logic [31:0] mag;
	logic [63:0] load_vec;
	logic [4:0]  pfx_len;
	logic        trim_shift;
	i2a_pkg::cell_op_t op;

	logic [i2a_pkg::NIB_W-1:0] nib   [i2a_pkg::NUM_CELLS];
	logic                      carry [i2a_pkg::NUM_CELLS];
	logic [i2a_pkg::NIB_W-1:0] top_nib;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign emit_ok    = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign character  = char_q;
	assign is_last    = last_q;
	assign char_count = count_q;

	assign is_dec = (command == i2a_pkg::CMD_SDEC) || (command == i2a_pkg::CMD_UDEC);
	assign is_hex = (command == i2a_pkg::CMD_HEXL) || (command == i2a_pkg::CMD_HEXU);
	assign is_ptr = (command == i2a_pkg::CMD_PTR);
	assign neg_in = (command == i2a_pkg::CMD_SDEC) && value[31];
	assign mag    = neg_in ? (32'd0 - value[31:0]) : value[31:0];

	always_comb begin
		if (is_ptr) begin
			load_vec = value;
		end else if (is_hex) begin
			load_vec = {32'd0, value[31:0]};
		end else begin
			load_vec = 64'd0;
		end
	end

	assign top_nib    = nib[i2a_pkg::NUM_CELLS-1];
	assign trim_shift = (top_nib == 4'd0) && (ndig_q > 5'd1);
	assign pfx_len    = ptr_q ? 5'd2 : (neg_q ? 5'd1 : 5'd0);

	always_comb begin
		case (state_q)
			ST_IDLE:   op = in_fire ? i2a_pkg::CELL_LOAD : i2a_pkg::CELL_HOLD;
			ST_CONV:   op = i2a_pkg::CELL_DABBLE;
			ST_TRIM:   op = trim_shift ? i2a_pkg::CELL_SHIFT : i2a_pkg::CELL_HOLD;
			ST_DIGITS: op = emit_ok ? i2a_pkg::CELL_SHIFT : i2a_pkg::CELL_HOLD;
			default:   op = i2a_pkg::CELL_HOLD;
		endcase
	end

	// digit row: cell 0 is least significant and takes the binary msb
	for (genvar i = 0; i < i2a_pkg::NUM_CELLS; i++) begin : g_cell
		if (i == 0) begin : g_first
			i2a_cell u_cell (
				.clk      (clk),
				.op       (op),
				.load_nib (load_vec[i*i2a_pkg::NIB_W +: i2a_pkg::NIB_W]),
				.nib_in   (4'd0),
				.bit_in   (bin_q[31]),
				.nib      (nib[i]),
				.bit_out  (carry[i])
			);
		end else begin : g_rest
			i2a_cell u_cell (
				.clk      (clk),
				.op       (op),
				.load_nib (load_vec[i*i2a_pkg::NIB_W +: i2a_pkg::NIB_W]),
				.nib_in   (nib[i-1]),
				.bit_in   (carry[i-1]),
				.nib      (nib[i]),
				.bit_out  (carry[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						bin_q   <= mag;
						cnt_q   <= 5'(i2a_pkg::CONV_STEPS - 1);
						ndig_q  <= 5'(i2a_pkg::NUM_CELLS);
						neg_q   <= neg_in;
						ptr_q   <= is_ptr;
						upper_q <= (command == i2a_pkg::CMD_HEXU);
						if (is_dec) begin
							state_q <= ST_CONV;
						end else if (is_hex || is_ptr) begin
							state_q <= ST_TRIM;
						end
					end
				end
				ST_CONV: begin
					bin_q <= {bin_q[30:0], 1'b0};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM: begin
					// drop leading zero digits, keep at least one
					if (trim_shift) begin
						ndig_q <= ndig_q - 5'd1;
					end else begin
						total_q <= ndig_q + pfx_len;
						state_q <= (neg_q || ptr_q) ? ST_PFX0 : ST_DIGITS;
					end
				end
				ST_PFX0: begin
					if (emit_ok) begin
						char_q      <= neg_q ? i2a_pkg::CH_MINUS : i2a_pkg::CH_ZERO;
						last_q      <= 1'b0;
						count_q     <= 5'd0;
						out_valid_q <= 1'b1;
						state_q     <= ptr_q ? ST_PFX1 : ST_DIGITS;
					end
				end
				ST_PFX1: begin
					if (emit_ok) begin
						char_q      <= i2a_pkg::CH_X;
						last_q      <= 1'b0;
						count_q     <= 5'd0;
						out_valid_q <= 1'b1;
						state_q     <= ST_DIGITS;
					end
				end
				ST_DIGITS: begin
					if (emit_ok) begin
						char_q      <= i2a_pkg::hex_char(top_nib, upper_q);
						last_q      <= (ndig_q == 5'd1);
						count_q     <= (ndig_q == 5'd1) ? total_q : 5'd0;
						out_valid_q <= 1'b1;
						ndig_q      <= ndig_q - 5'd1;
						if (ndig_q == 5'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_digits_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGITS) |-> (ndig_q != 5'd0))
		else $error("digit emission with no digits left");

	a_last_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (count_q != 5'd0 && count_q <= 5'd18))
		else $error("final character carries a bad count");

	a_mid_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> (count_q == 5'd0))
		else $error("count shown on a non-final character");

	a_conv_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV && cnt_q == 5'd0) |=> (state_q == ST_TRIM))
		else $error("conversion did not end after its last step");

	a_bad_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (command > i2a_pkg::CMD_PTR))
		|=> (state_q == ST_IDLE))
		else $error("unused command started formatting");
`endif

endmodule
`default_nettype wire

// ----- hdl/i2a_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_cell
// One digit cell: holds a nibble, loads it, runs one double-dabble step with
// its neighbors, or takes the nibble of the cell below.
// ----------------------------------------------------------------------------
module i2a_cell (
	input  wire logic                      clk,
	input  wire i2a_pkg::cell_op_t         op,
	input  wire logic [i2a_pkg::NIB_W-1:0] load_nib,
	input  wire logic [i2a_pkg::NIB_W-1:0] nib_in,
	input  wire logic                      bit_in,
	output logic      [i2a_pkg::NIB_W-1:0] nib,
	output logic                           bit_out
);

	logic [i2a_pkg::NIB_W-1:0] digit_q;
	logic [i2a_pkg::NIB_W-1:0] adj;

	// add three before the shift when the digit would overflow past nine
	assign adj     = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
	assign bit_out = adj[3];
	assign nib     = digit_q;

	always_ff @(posedge clk) begin
		case (op)
			i2a_pkg::CELL_LOAD:   digit_q <= load_nib;
			i2a_pkg::CELL_DABBLE: digit_q <= {adj[2:0], bit_in};
			i2a_pkg::CELL_SHIFT:  digit_q <= nib_in;
			default:              digit_q <= digit_q;
		endcase
	end

endmodule
`default_nettype wire
